@@ hw/rtl/periodic_substitution_cipher_top_defines.svh @@
// Assertion macros for the periodic substitution cipher.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef PERIODIC_SUBSTITUTION_CIPHER_TOP_DEFINES_SVH
`define PERIODIC_SUBSTITUTION_CIPHER_TOP_DEFINES_SVH

// same-cycle implication
`define PSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psc assertion failed");

// next-cycle implication
`define PSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psc assertion failed");

`endif

@@ hw/rtl/psc_pkg.sv @@
// Shared types and constants of the periodic substitution cipher.
// No dependencies.
package psc_pkg;

  localparam int PSC_MAX_PERIOD = 16;
  localparam int PSC_FIFO_DEPTH = 4;
  localparam int PSC_LETTERS    = 26;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_ENCODE  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_FORMAT    = 2'd2;

  localparam logic [7:0] CH_NEWLINE  = 8'd10;
  localparam logic [7:0] CH_PRINT_LO = 8'd32;
  localparam logic [7:0] CH_PRINT_HI = 8'd126;
  localparam logic [7:0] CH_LOWER_A  = 8'd97;
  localparam logic [7:0] CH_LOWER_Z  = 8'd122;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_LOOKUP,
    CMD_PASS
  } psc_cmd_e;

  typedef struct packed {
    psc_cmd_e   cmd;
    logic [1:0] status;
    logic [7:0] data;
  } psc_op_t;

endpackage

@@ hw/rtl/psc_fifo.sv @@
// Small register queue between the front and back parts.
// Depth must be a power of two. Uses no package.
module psc_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? PW'(wptr_q + 1'b1) : wptr_q;
    rptr_d = do_pop ? PW'(rptr_q + 1'b1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = CW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end
endmodule

@@ hw/rtl/psc_front.sv @@
// Front part: accepts items, holds row position, flags and period, classifies.
// Depends on psc_pkg.
module psc_front import psc_pkg::*; #(
  parameter int MaxPeriod = PSC_MAX_PERIOD,
  parameter int AW        = $clog2(PSC_MAX_PERIOD * PSC_LETTERS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [4:0]    cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    op_i,
  input  logic [3:0]    key_row_i,
  input  logic [4:0]    key_letter_i,
  input  logic [7:0]    key_value_i,
  input  logic [7:0]    char_in_i,
  input  logic          full_i,
  output logic          push_o,
  output psc_op_t       cmd_o,
  output logic [AW-1:0] addr_o
);
  localparam int RW  = (MaxPeriod > 1) ? $clog2(MaxPeriod) : 1;
  localparam int MCW = $clog2(MaxPeriod + 1);
  localparam int CW  = (MCW > 5) ? MCW : 5;

  logic [4:0]    period_q;
  logic [RW-1:0] row_q, row_d;
  logic          malformed_q, malformed_d;
  logic          fmt_err_q, fmt_err_d;

  logic          accept, need_push;
  logic [CW-1:0] per_ext, span, row_ext, cur_ext, nxt_ext;
  logic [RW-1:0] cur_row;
  logic          load_ok, printable, lower;
  logic [4:0]    letter_off;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign push_o      = accept && need_push;

  always_comb begin
    per_ext = CW'(period_q);
    if (per_ext == '0) begin
      span = CW'(1);
    end else if (per_ext > CW'(MaxPeriod)) begin
      span = CW'(MaxPeriod);
    end else begin
      span = per_ext;
    end
    row_ext = CW'(row_q);
    cur_ext = (row_ext < span) ? row_ext : '0;
    nxt_ext = CW'(cur_ext + 1'b1);
    if (nxt_ext >= span) begin
      nxt_ext = '0;
    end
    cur_row = RW'(cur_ext);
  end

  assign load_ok    = (key_letter_i < 5'(PSC_LETTERS)) && (32'(key_row_i) < 32'(MaxPeriod));
  assign printable  = (char_in_i >= CH_PRINT_LO) && (char_in_i <= CH_PRINT_HI);
  assign lower      = (char_in_i >= CH_LOWER_A) && (char_in_i <= CH_LOWER_Z);
  assign letter_off = 5'(char_in_i - CH_LOWER_A);

  always_comb begin
    row_d        = row_q;
    malformed_d  = malformed_q;
    fmt_err_d    = fmt_err_q;
    need_push    = 1'b0;
    cmd_o.cmd    = CMD_PASS;
    cmd_o.status = ST_OK;
    cmd_o.data   = '0;
    addr_o       = '0;
    case (op_i)
      OP_LOAD: begin
        if (load_ok) begin
          need_push = 1'b1;
          cmd_o.cmd  = CMD_WRITE;
          cmd_o.data = key_value_i;
          addr_o     = AW'(AW'(key_row_i) * AW'(PSC_LETTERS)) + AW'(key_letter_i);
          if ((key_value_i < CH_LOWER_A) || (key_value_i > CH_LOWER_Z)) begin
            malformed_d = 1'b1;
          end
        end
      end
      OP_ENCODE: begin
        need_push = 1'b1;
        if (malformed_q) begin
          cmd_o.status = ST_MALFORMED;
        end else if (fmt_err_q) begin
          cmd_o.status = ST_FORMAT;
        end else if (char_in_i == CH_NEWLINE) begin
          cmd_o.data = char_in_i;
        end else if (printable) begin
          row_d = RW'(nxt_ext);
          if (lower) begin
            cmd_o.cmd = CMD_LOOKUP;
            addr_o    = AW'(AW'(cur_row) * AW'(PSC_LETTERS)) + AW'(letter_off);
          end else begin
            cmd_o.data = char_in_i;
          end
        end else begin
          fmt_err_d    = 1'b1;
          cmd_o.status = ST_FORMAT;
        end
      end
      OP_RESTART: begin
        row_d     = '0;
        fmt_err_d = 1'b0;
      end
      default: begin
        need_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= 5'd1;
      row_q       <= '0;
      malformed_q <= 1'b0;
      fmt_err_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        period_q <= cfg_data_i;
      end
      if (accept) begin
        row_q       <= row_d;
        malformed_q <= malformed_d;
        fmt_err_q   <= fmt_err_d;
      end
    end
  end
endmodule

@@ hw/rtl/psc_back.sv @@
// Back part: key table memory, lookups and the output register.
// Depends on psc_pkg.
module psc_back import psc_pkg::*; #(
  parameter int MaxPeriod = PSC_MAX_PERIOD,
  parameter int AW        = $clog2(PSC_MAX_PERIOD * PSC_LETTERS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  output logic          pop_o,
  input  psc_op_t       cmd_i,
  input  logic [AW-1:0] addr_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    char_out_o,
  output logic [1:0]    status_o
);
  localparam int KtDepth = MaxPeriod * PSC_LETTERS;

  logic [7:0] key_mem_q [KtDepth];
  logic [7:0] rd_q;
  logic       valid_q;
  psc_op_t    op_q;

  assign pop_o       = !empty_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign status_o    = op_q.status;
  assign char_out_o  = (op_q.cmd == CMD_LOOKUP) ? rd_q : op_q.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= (cmd_i.cmd != CMD_WRITE);
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q <= cmd_i;
      if (cmd_i.cmd == CMD_WRITE) begin
        key_mem_q[addr_i] <= cmd_i.data;
      end
      if (cmd_i.cmd == CMD_LOOKUP) begin
        rd_q <= key_mem_q[addr_i];
      end
    end
  end
endmodule

@@ hw/rtl/periodic_substitution_cipher_top.sv @@
// Periodic polyalphabetic substitution cipher, one character per cycle unless stalled.
// A front part classifies each transaction against the row position and the
// sticky flags, a four-entry queue decouples it from a back part that owns the
// key table memory (MaxPeriod*26 bytes, one access a cycle) and the output
// register. Loads, encodes and restarts are each taken while the queue is not
// full; an encode result passes through the queue and then the output register
// before it is offered on the output. Input is held back only when the queue
// is full, so throughput stays at one transaction per cycle while the output
// side keeps up.
`include "periodic_substitution_cipher_top_defines.svh"
module periodic_substitution_cipher_top import psc_pkg::*; #(
  parameter int MaxPeriod = PSC_MAX_PERIOD,
  parameter int FifoDepth = PSC_FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,     // period
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // key_row, key_letter, key_value, char_in, zero fill
  input  logic [1:0]  s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // char_out
  output logic [1:0]  m_axis_tuser    // status
);
  localparam int AW = $clog2(MaxPeriod * PSC_LETTERS);
  localparam int OW = $bits(psc_op_t);
  localparam int QW = OW + AW;

  logic          push, pop, full, empty;
  psc_op_t       f_cmd, b_cmd;
  logic [AW-1:0] f_addr, b_addr;
  logic [QW-1:0] q_wdata, q_rdata;

  psc_front #(
    .MaxPeriod(MaxPeriod),
    .AW       (AW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .key_row_i   (s_axis_tdata[3:0]),
    .key_letter_i(s_axis_tdata[8:4]),
    .key_value_i (s_axis_tdata[16:9]),
    .char_in_i   (s_axis_tdata[24:17]),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (f_cmd),
    .addr_o      (f_addr)
  );

  assign q_wdata = {f_addr, f_cmd};
  assign b_cmd   = q_rdata[OW-1:0];
  assign b_addr  = q_rdata[QW-1:OW];

  psc_fifo #(
    .Width(QW),
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(q_wdata),
    .full_o (full),
    .pop_i  (pop),
    .rdata_o(q_rdata),
    .empty_o(empty)
  );

  psc_back #(
    .MaxPeriod(MaxPeriod),
    .AW       (AW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .pop_o      (pop),
    .cmd_i      (b_cmd),
    .addr_i     (b_addr),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .char_out_o (m_axis_tdata),
    .status_o   (m_axis_tuser)
  );

  `PSC_ASSERT_NOW(a_err_zero_char, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata == 8'd0)
  `PSC_ASSERT_NOW(a_full_stalls, full, !s_axis_tready)
  `PSC_ASSERT_NOW(a_status_code, m_axis_tvalid, m_axis_tuser <= ST_FORMAT)
  `PSC_ASSERT_NEXT(a_pop_needs_data, empty, !$past(push) || !empty)
endmodule

@@ test/periodic_substitution_cipher_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for periodic_substitution_cipher_top: random stream traffic
// with gaps on both sides, predicted per transaction by a scoreboard class.
// Depends on psc_pkg and the cipher RTL only.
module periodic_substitution_cipher_top_tb;
  import psc_pkg::*;

  localparam logic [1:0] OP_IGNORED     = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] status;
  } cipher_result_t;

  class substitution_scoreboard;
    logic [7:0]     key_table   [PSC_MAX_PERIOD][PSC_LETTERS];
    bit             key_written [PSC_MAX_PERIOD][PSC_LETTERS];
    int             row_pos;
    bit             key_malformed;
    bit             format_error;
    logic [4:0]     period;
    cipher_result_t expected_chars [$];
    int             mismatches;

    function new();
      row_pos       = 0;
      key_malformed = 1'b0;
      format_error  = 1'b0;
      period        = 5'd1;
      mismatches    = 0;
      foreach (key_written[r, l]) key_written[r][l] = 1'b0;
    endfunction

    function int span();
      if (period == 5'd0) return 1;
      if (period > PSC_MAX_PERIOD) return PSC_MAX_PERIOD;
      return int'(period);
    endfunction

    function int current_row();
      return (row_pos < span()) ? row_pos : 0;
    endfunction

    function bit is_lower(logic [7:0] ch);
      return (ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z);
    endfunction

    // true when encoding ch now would read a key entry never loaded
    function bit reads_blank(logic [7:0] ch);
      if (key_malformed || format_error || !is_lower(ch)) return 1'b0;
      return !key_written[current_row()][ch - CH_LOWER_A];
    endfunction

    function void note_item(logic [1:0] op, logic [3:0] row, logic [4:0] letter,
                            logic [7:0] value, logic [7:0] ch);
      cipher_result_t res;
      int             cur;
      if (op == OP_LOAD) begin
        if (letter < PSC_LETTERS) begin
          key_table[row][letter]   = value;
          key_written[row][letter] = 1'b1;
          if (!is_lower(value)) key_malformed = 1'b1;
        end
      end else if (op == OP_RESTART) begin
        row_pos      = 0;
        format_error = 1'b0;
      end else if (op == OP_ENCODE) begin
        res.ch     = 8'd0;
        res.status = ST_OK;
        if (key_malformed) begin
          res.status = ST_MALFORMED;
        end else if (format_error) begin
          res.status = ST_FORMAT;
        end else if (ch == CH_NEWLINE) begin
          res.ch = ch;
        end else if ((ch >= CH_PRINT_LO) && (ch <= CH_PRINT_HI)) begin
          cur     = current_row();
          row_pos = (cur + 1 >= span()) ? 0 : cur + 1;
          res.ch  = is_lower(ch) ? key_table[cur][ch - CH_LOWER_A] : ch;
        end else begin
          format_error = 1'b1;
          res.status   = ST_FORMAT;
        end
        expected_chars.push_back(res);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic [1:0] status);
      cipher_result_t want;
      if (expected_chars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, expected none, actual char_out %0d status %0d",
                 $time, ch, status);
        return;
      end
      want = expected_chars.pop_front();
      if (ch !== want.ch) begin
        mismatches++;
        $display("%0t: char_out mismatch, expected %0d, actual %0d", $time, want.ch, ch);
      end
      if (status !== want.status) begin
        mismatches++;
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, status);
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i    = 5'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = 32'd0;  // key_row, key_letter, key_value, char_in, zero fill
  logic [1:0]  s_axis_tuser  = 2'd0;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;           // char_out
  logic [1:0]  m_axis_tuser;           // status

  substitution_scoreboard board;
  bit steady_mode = 1'b0;
  int idle_cycles = 0;
  int stall_left  = 0;
  int items_sent  = 0;

  periodic_substitution_cipher_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] random_lower();
    return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
  endfunction

  function automatic logic [7:0] other_printable();
    logic [7:0] v;
    do v = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
    while ((v >= CH_LOWER_A) && (v <= CH_LOWER_Z));
    return v;
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255));
    while ((v == CH_NEWLINE) || ((v >= CH_PRINT_LO) && (v <= CH_PRINT_HI)));
    return v;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_char(m_axis_tdata, m_axis_tuser);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!steady_mode && ($urandom_range(0, 5) == 0)) stall_left = pick_gap();
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic send_item(input logic [1:0] op, input logic [3:0] row,
                           input logic [4:0] letter, input logic [7:0] value,
                           input logic [7:0] ch);
    int gap;
    gap = steady_mode ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, ch, value, letter, row};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(op, row, letter, value, ch);
    items_sent++;
  endtask

  // load the key entry first where the letter would hit an empty one
  task automatic encode_char(input logic [7:0] ch);
    if (board.reads_blank(ch)) begin
      send_item(OP_LOAD, 4'(board.current_row()), 5'(ch - CH_LOWER_A), random_lower(),
                8'($urandom));
    end
    send_item(OP_ENCODE, 4'($urandom), 5'($urandom), 8'($urandom), ch);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.expected_chars.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_period(input logic [4:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.period = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_message();
    int len;
    int pick;
    send_item(OP_RESTART, 4'($urandom), 5'($urandom), 8'($urandom), 8'($urandom));
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(3, 20);
    repeat (len) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        encode_char(random_lower());
      end else if (pick < 68) begin
        encode_char(other_printable());
      end else if (pick < 76) begin
        encode_char(CH_NEWLINE);
      end else if (pick < 84) begin
        send_item(OP_LOAD, 4'($urandom), 5'($urandom_range(0, PSC_LETTERS - 1)),
                  random_lower(), 8'($urandom));
      end else if (pick < 88) begin
        send_item(OP_IGNORED, 4'($urandom), 5'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 91) begin
        send_item(OP_LOAD, 4'($urandom), 5'($urandom_range(PSC_LETTERS, 31)),
                  8'($urandom), 8'($urandom));
      end else if (pick < 92) begin
        drain_results();
      end else if (pick < 95) begin
        encode_char(bad_char());
      end else begin
        send_item(OP_RESTART, 4'($urandom), 5'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic run_phase(input logic [4:0] value, input int count, input bit steady);
    int target;
    write_period(value);
    steady_mode = steady;
    target = items_sent + count;
    while (items_sent < target) run_message();
    steady_mode = 1'b0;
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_period(5'd2);
    encode_char(CH_LOWER_A);
    encode_char(CH_LOWER_Z);
    encode_char(CH_PRINT_LO);
    encode_char(CH_PRINT_HI);
    encode_char("m");
    encode_char(CH_NEWLINE);
    encode_char(CH_LOWER_A);
    send_item(OP_LOAD, 4'd15, 5'd25, CH_LOWER_Z, 8'd0);
    send_item(OP_LOAD, 4'd0, 5'd0, CH_LOWER_A, 8'd0);
    send_item(OP_LOAD, 4'd3, 5'd31, 8'hff, 8'hff);
    send_item(OP_LOAD, 4'd15, 5'd26, 8'h00, 8'h00);
    send_item(OP_IGNORED, 4'hf, 5'h1f, 8'hff, 8'hff);
    encode_char(CH_LOWER_A);
    encode_char(8'd31);
    encode_char(CH_NEWLINE);
    encode_char(CH_LOWER_A);
    encode_char(8'hff);
    send_item(OP_RESTART, 4'd0, 5'd0, 8'd0, 8'd0);
    encode_char(CH_LOWER_Z);
    encode_char(8'd127);
    send_item(OP_RESTART, 4'hf, 5'h1f, 8'hff, 8'hff);
    encode_char(8'd0);
    send_item(OP_RESTART, 4'd0, 5'd0, 8'd0, 8'd0);

    run_phase(5'd16, 180, 1'b0);
    run_phase(5'd3, 175, 1'b0);
    run_phase(5'd0, 175, 1'b0);
    run_phase(5'd31, 175, 1'b1);
    run_phase(5'd1, 175, 1'b0);
    run_phase(5'd7, 175, 1'b0);
    run_phase(5'd5, 165, 1'b0);

    // a bad key byte is sticky until reset, so it comes last
    write_period(5'd4);
    send_item(OP_LOAD, 4'd9, 5'd4, 8'd0, 8'd0);
    encode_char(CH_LOWER_A);
    encode_char(CH_NEWLINE);
    encode_char(bad_char());
    send_item(OP_LOAD, 4'd2, 5'd0, 8'd96, 8'd0);
    send_item(OP_LOAD, 4'd2, 5'd25, 8'd123, 8'd0);
    send_item(OP_LOAD, 4'd0, 5'd7, 8'hff, 8'd0);
    run_phase(5'd4, 40, 1'b0);

    drain_results();
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
